### rtl/lbs_pkg.sv
// Shared types and constants of the linear blend skinning block.
// Holds command codes, item structs, sequencer enums and datapath widths.
// No dependencies.
`default_nettype none

package lbs_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned JOINT_W  = 6;
  localparam int unsigned ELEM_W   = 4;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 2;
  localparam int unsigned ROW_W    = 2;

  // Datapath widths
  localparam int unsigned ACC_W  = 64;  // accumulator
  localparam int unsigned MULA_W = 35;  // multiplier operand a
  localparam int unsigned MULB_W = 33;  // multiplier operand b
  localparam int unsigned PROD_W = MULA_W + MULB_W;
  localparam int unsigned SUM_W  = 66;  // sum of three Q32.32 products
  localparam int unsigned P_W    = 51;  // affine row result, Q35.16
  localparam int unsigned PART_W = 17;  // (lo * w) >> 16
  localparam int unsigned C_W    = 54;  // weighted contribution
  localparam int unsigned FRAC_W = 16;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TERM = 1'b1;

  localparam logic [ELEM_W-1:0]   ELEM_COUNT = 4'd12;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // Matrix rows / accumulator entries
  localparam logic [ROW_W-1:0] ROW_X = 2'd0;
  localparam logic [ROW_W-1:0] ROW_Y = 2'd1;
  localparam logic [ROW_W-1:0] ROW_Z = 2'd2;

  typedef logic [LANES-1:0][COORD_W-1:0] xrow_t;

  typedef struct packed {
    logic                       command;
    logic [JOINT_W-1:0]         joint;
    logic [ELEM_W-1:0]          element;
    logic signed [COORD_W-1:0]  element_value;
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    logic signed [COORD_W-1:0]  vertex_z;
    logic [WEIGHT_W-1:0]        weight;
    logic                       last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Per-row step sequence of the shared multiplier datapath
  typedef enum logic [3:0] {
    STEP_M0,   // T0 * vx
    STEP_M1,   // T1 * vy
    STEP_M2,   // T2 * vz
    STEP_SUM,  // last product into the sum
    STEP_P,    // p = floor(sum / 2^16) + T3
    STEP_MLO,  // lo16(p) * w
    STEP_MHI,  // hi(p) * w
    STEP_C,    // c = hi*w + (lo*w >> 16)
    STEP_ACC   // accumulator read-modify-write
  } step_t;

  typedef struct packed {
    logic  active;
    step_t step;
  } row_ctl_t;

endpackage

`default_nettype wire

### rtl/lbs_xform_mem.sv
// Transform table: one 4-lane word per matrix row, one lane written at a time.
// Synchronous, registered read. Depends on lbs_pkg.
`default_nettype none

module lbs_xform_mem
  import lbs_pkg::*;
#(
  parameter int unsigned DEPTH = 72,
  parameter int unsigned AW    = 7
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [LANE_W-1:0]   wr_lane,
  input  wire logic [COORD_W-1:0]  wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output xrow_t                    rd_data
);

  xrow_t mem_r [DEPTH];
  xrow_t rd_data_r;

  // Lane write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr][wr_lane] <= wr_data;
    end
  end

  // Registered read; data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/lbs_acc_mem.sv
// Accumulator store: three 64-bit entries with valid bits, zero when not valid.
// Synchronous, registered read, bulk clear. Depends on lbs_pkg.
`default_nettype none

module lbs_acc_mem
  import lbs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [ROW_W-1:0]        rd_addr,
  output logic signed [ACC_W-1:0]      rd_data,
  input  wire logic                    wr_en,
  input  wire logic [ROW_W-1:0]        wr_addr,
  input  wire logic signed [ACC_W-1:0] wr_data,
  input  wire logic                    clr
);

  logic [ACC_W-1:0] mem_r [3];
  logic [2:0]       vld_r;
  logic [ACC_W-1:0] rd_q_r;
  logic             hit_r;

  // Valid bits: cleared by reset and after each emitted vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = hit_r ? $signed(rd_q_r) : '0;

endmodule

`default_nettype wire

### rtl/lbs_row_unit.sv
// Row datapath: one shared signed multiplier stepped through an affine row,
// the weight scaling and the saturating accumulate. Depends on lbs_pkg.
`default_nettype none

module lbs_row_unit
  import lbs_pkg::*;
(
  input  wire logic                      clk,
  input  wire row_ctl_t                  ctl,
  input  wire xrow_t                     t_row,
  input  wire logic signed [COORD_W-1:0] vx,
  input  wire logic signed [COORD_W-1:0] vy,
  input  wire logic signed [COORD_W-1:0] vz,
  input  wire logic [WEIGHT_W-1:0]       w,
  input  wire logic signed [ACC_W-1:0]   acc_q,
  output logic signed [ACC_W-1:0]        acc_new
);

  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         sum_r;
  logic [P_W-1:0]           p_r;
  logic [P_W-1:0]           p_nxt;
  logic [PART_W-1:0]        part_r;
  logic [C_W-1:0]           c_r;
  logic [ACC_W:0]           acc_sum;

  // Operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.step)
      STEP_M0: begin
        mul_a = {{(MULA_W-COORD_W){t_row[0][COORD_W-1]}}, t_row[0]};
        mul_b = {{(MULB_W-COORD_W){vx[COORD_W-1]}}, vx};
      end
      STEP_M1: begin
        mul_a = {{(MULA_W-COORD_W){t_row[1][COORD_W-1]}}, t_row[1]};
        mul_b = {{(MULB_W-COORD_W){vy[COORD_W-1]}}, vy};
      end
      STEP_M2: begin
        mul_a = {{(MULA_W-COORD_W){t_row[2][COORD_W-1]}}, t_row[2]};
        mul_b = {{(MULB_W-COORD_W){vz[COORD_W-1]}}, vz};
      end
      STEP_MLO: begin
        mul_a = {{(MULA_W-FRAC_W){1'b0}}, p_r[FRAC_W-1:0]};
        mul_b = {{(MULB_W-WEIGHT_W){1'b0}}, w};
      end
      STEP_MHI: begin
        mul_a = p_r[P_W-1:FRAC_W];
        mul_b = {{(MULB_W-WEIGHT_W){1'b0}}, w};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // p = floor(sum / 2^16) + T3
  assign p_nxt = {sum_r[SUM_W-1], sum_r[SUM_W-1:FRAC_W]}
               + {{(P_W-COORD_W){t_row[3][COORD_W-1]}}, t_row[3]};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.active) begin
      case (ctl.step)
        STEP_M1:  sum_r  <= prod_r[SUM_W-1:0];
        STEP_M2:  sum_r  <= sum_r + prod_r[SUM_W-1:0];
        STEP_SUM: sum_r  <= sum_r + prod_r[SUM_W-1:0];
        STEP_P:   p_r    <= p_nxt;
        STEP_MHI: part_r <= prod_r[FRAC_W+PART_W-1:FRAC_W];
        STEP_C:   c_r    <= prod_r[C_W-1:0] + {{(C_W-PART_W){1'b0}}, part_r};
        default: ;
      endcase
    end
  end

  // Saturating 64-bit accumulate
  assign acc_sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-C_W){c_r[C_W-1]}}, c_r};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/linear_blend_skinning_top.sv
// Top level of the linear blend skinning block: sequencer, output register,
// transform table, accumulator store and row datapath. Depends on lbs_pkg.
//
//  channel | ports                       | moves
//  --------+-----------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data | one load or skinning term (in_item_t)
//  result  | out_valid, out_ready,       | one skinned vertex (out_item_t)
//          | out_data                    |
//
// A load writes one table lane in ST_IDLE. A skinning term takes one table read, then
// 9 steps for each of the 3 matrix rows through the single 35x33 multiplier.
// A term marked last then reads and clips the accumulators; a skipped term
// (zero weight or joint out of range) runs no steps and goes straight to that read when last.
// Reset clears the sequencer and the accumulator valid bits at once; the
// transform table is not cleared. A result waits in the output register
// while new items are taken; only the next emit stalls on it.
`default_nettype none

module linear_blend_skinning_top
  import lbs_pkg::*;
#(
  parameter int unsigned JOINT_COUNT = 24,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int unsigned XDEPTH  = JOINT_COUNT * 3;
  localparam int unsigned XAW     = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int unsigned OUTBITS = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic [JOINT_W:0] JointLimit = (JOINT_W+1)'(JOINT_COUNT);
  localparam logic signed [ACC_W-1:0] ClipHi = (64'sd1 <<< (OUTBITS-1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] ClipLo = -ClipHi - 64'sd1;

  state_t                    state_r, state_nxt;
  step_t                     step_r, step_nxt, step_inc;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [XAW-1:0]            base_r, base_nxt;
  logic signed [COORD_W-1:0] vx_r, vy_r, vz_r;
  logic [WEIGHT_W-1:0]       w_r, w_clamp;
  logic                      last_r;
  logic [COORD_W-1:0]        stage_x_r, stage_x_nxt;
  logic [COORD_W-1:0]        stage_y_r, stage_y_nxt;
  logic                      stage_sat_r, stage_sat_nxt;
  out_item_t                 out_r;
  logic                      out_valid_r, out_valid_nxt;

  logic                      accept;
  logic                      joint_ok, elem_ok, term_live;
  logic [JOINT_W+1:0]        joint_x3;
  logic [XAW-1:0]            in_base;
  logic                      emit_load;
  logic                      out_free;

  logic                      xwr_en, xrd_en;
  logic [XAW-1:0]            xwr_addr, xrd_addr;
  xrow_t                     xrd_data;

  logic                      ard_en, awr_en, aclr;
  logic [ROW_W-1:0]          ard_addr;
  logic signed [ACC_W-1:0]   ard_data, acc_new;

  logic [COORD_W-1:0]        clip_val;
  logic                      clip_flag;
  row_ctl_t                  row_ctl;

  // Input decode
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign joint_ok  = {1'b0, in_data.joint} < JointLimit;
  assign elem_ok   = in_data.element < ELEM_COUNT;
  assign w_clamp   = (in_data.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_data.weight;
  assign term_live = joint_ok && (in_data.weight != '0);
  assign joint_x3  = {1'b0, in_data.joint, 1'b0} + {2'b00, in_data.joint};
  assign in_base   = XAW'(joint_x3);
  assign xwr_addr  = XAW'(in_base + XAW'(in_data.element[ELEM_W-1:LANE_W]));
  assign out_free  = !out_valid_r || out_ready;

  // Clip accumulator read data to the output range
  always_comb begin
    clip_flag = 1'b0;
    clip_val  = ard_data[COORD_W-1:0];
    if (ard_data > ClipHi) begin
      clip_val  = ClipHi[COORD_W-1:0];
      clip_flag = 1'b1;
    end else if (ard_data < ClipLo) begin
      clip_val  = ClipLo[COORD_W-1:0];
      clip_flag = 1'b1;
    end
  end

  // Step sequence of one row
  always_comb begin
    unique case (step_r)
      STEP_M0:  step_inc = STEP_M1;
      STEP_M1:  step_inc = STEP_M2;
      STEP_M2:  step_inc = STEP_SUM;
      STEP_SUM: step_inc = STEP_P;
      STEP_P:   step_inc = STEP_MLO;
      STEP_MLO: step_inc = STEP_MHI;
      STEP_MHI: step_inc = STEP_C;
      STEP_C:   step_inc = STEP_ACC;
      default:  step_inc = STEP_M0;
    endcase
  end

  // Sequencer: next state and memory controls
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    stage_x_nxt   = stage_x_r;
    stage_y_nxt   = stage_y_r;
    stage_sat_nxt = stage_sat_r;
    xwr_en        = 1'b0;
    xrd_en        = 1'b0;
    xrd_addr      = base_r;
    ard_en        = 1'b0;
    ard_addr      = row_r;
    awr_en        = 1'b0;
    aclr          = 1'b0;
    emit_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_LOAD) begin
            xwr_en = joint_ok && elem_ok;
          end else if (term_live) begin
            xrd_en    = 1'b1;
            xrd_addr  = in_base;
            base_nxt  = in_base;
            state_nxt = ST_CALC;
            step_nxt  = STEP_M0;
            row_nxt   = ROW_X;
          end else if (in_data.last_term) begin
            ard_en    = 1'b1;
            ard_addr  = ROW_X;
            state_nxt = ST_EMIT;
            row_nxt   = ROW_X;
          end
        end
      end
      ST_CALC: begin
        step_nxt = step_inc;
        case (step_r)
          STEP_P: begin
            // prefetch the next matrix row; T3 is consumed this cycle
            if (row_r != ROW_Z) begin
              xrd_en   = 1'b1;
              xrd_addr = XAW'(base_r + XAW'(row_r) + XAW'(1));
            end
          end
          STEP_C: ard_en = 1'b1;
          STEP_ACC: begin
            awr_en = 1'b1;
            if (row_r == ROW_Z) begin
              row_nxt = ROW_X;
              if (last_r) begin
                ard_en    = 1'b1;
                ard_addr  = ROW_X;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        case (row_r)
          ROW_X: begin
            stage_x_nxt   = clip_val;
            stage_sat_nxt = clip_flag;
            ard_en        = 1'b1;
            ard_addr      = ROW_Y;
            row_nxt       = ROW_Y;
          end
          ROW_Y: begin
            stage_y_nxt   = clip_val;
            stage_sat_nxt = stage_sat_r | clip_flag;
            ard_en        = 1'b1;
            ard_addr      = ROW_Z;
            row_nxt       = ROW_Z;
          end
          default: begin
            // hold until the output register is free
            if (out_free) begin
              emit_load = 1'b1;
              aclr      = 1'b1;
              state_nxt = ST_IDLE;
              row_nxt   = ROW_X;
            end
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_M0;
      row_r       <= ROW_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Term payload, captured on transfer
  always_ff @(posedge clk) begin
    if (accept && (in_data.command == CMD_TERM)) begin
      vx_r   <= in_data.vertex_x;
      vy_r   <= in_data.vertex_y;
      vz_r   <= in_data.vertex_z;
      w_r    <= w_clamp;
      last_r <= in_data.last_term;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    stage_x_r   <= stage_x_nxt;
    stage_y_r   <= stage_y_nxt;
    stage_sat_r <= stage_sat_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_r.out_x     <= stage_x_r;
      out_r.out_y     <= stage_y_r;
      out_r.out_z     <= clip_val;
      out_r.saturated <= stage_sat_r | clip_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign row_ctl.active = (state_r == ST_CALC);
  assign row_ctl.step   = step_r;

  lbs_xform_mem #(
    .DEPTH (XDEPTH),
    .AW    (XAW)
  ) u_xform_mem (
    .clk     (clk),
    .wr_en   (xwr_en),
    .wr_addr (xwr_addr),
    .wr_lane (in_data.element[LANE_W-1:0]),
    .wr_data (in_data.element_value),
    .rd_en   (xrd_en),
    .rd_addr (xrd_addr),
    .rd_data (xrd_data)
  );

  lbs_acc_mem u_acc_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ard_en),
    .rd_addr (ard_addr),
    .rd_data (ard_data),
    .wr_en   (awr_en),
    .wr_addr (row_r),
    .wr_data (acc_new),
    .clr     (aclr)
  );

  lbs_row_unit u_row_unit (
    .clk     (clk),
    .ctl     (row_ctl),
    .t_row   (xrd_data),
    .vx      (vx_r),
    .vy      (vy_r),
    .vz      (vz_r),
    .w       (w_r),
    .acc_q   (ard_data),
    .acc_new (acc_new)
  );

endmodule

`default_nettype wire

### rtl/lbs_checker.sv
// Port-level checks for the linear blend skinning top, attached by bind.
// Depends on lbs_pkg and linear_blend_skinning_top.
`default_nettype none

module lbs_checker
  import lbs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A load transfer leaves the block ready in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == CMD_LOAD) |=> in_ready)
    else $error("load did not complete in one cycle");

  // A zero-weight term that is not last adds nothing and leaves the block ready for the next item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == CMD_TERM) &&
    (in_data.weight == '0) && !in_data.last_term |=> in_ready)
    else $error("skipped term held the block");

  // A weighted term for joint 0 drops in_ready once it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == CMD_TERM) &&
    (in_data.weight != '0) && (in_data.joint == '0) |=> !in_ready)
    else $error("term accepted another item too early");

endmodule

bind linear_blend_skinning_top lbs_checker u_lbs_checker (.*);

`default_nettype wire
